@@ src/cpvp_pkg.sv @@
// Shared types, widths and constants for the cascaded position/velocity controller.
// Used by cpvp_div and cascaded_position_velocity_pid; no dependencies.
package cpvp_pkg;

	localparam int ERR_W      = 24;
	localparam int SPD_W      = 16;
	localparam int RATIO_W    = 32;
	localparam int DIST_W     = 23;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIVATIVE_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_RATIO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_RATIO      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_DISTANCE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_BRAKE_LEVEL = 3'd5;

	localparam logic signed [SPD_W-1:0] SLOW_SPEED = 16'sd26;
	localparam logic [63:0]             GAIN_STEP  = 64'd1163719657;

	typedef struct packed {
		logic               done;
		logic [RATIO_W-1:0] ratio;
	} div_rsp_t;

	// 5^(idx/20) in Q16.16, rounded per step, saturating at all ones
	function automatic logic [31:0] gain_entry(input int unsigned idx);
		logic [63:0] g;
		logic        sat;
		g   = 64'd65536;
		sat = 1'b0;
		for (int i = 0; i < 256; i++) begin
			if (i < idx && !sat) begin
				g = (g * GAIN_STEP + (64'd1 << 29)) >> 30;
				if (g > 64'hFFFF_FFFF) begin
					g   = 64'hFFFF_FFFF;
					sat = 1'b1;
				end
			end
		end
		return g[31:0];
	endfunction

endpackage

@@ src/cpvp_div.sv @@
// Bit-serial restoring divider: ratio = trunc(speed * 2^16 / error), one quotient bit a cycle.
// Depends on cpvp_pkg; error must be positive.
module cpvp_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cpvp_pkg::SPD_W-1:0]   spd,
	input  logic        [cpvp_pkg::DIST_W-1:0]  err,
	output cpvp_pkg::div_rsp_t                  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [4:0]                          cnt_q;
	logic [cpvp_pkg::RATIO_W-1:0]        dq_q;
	logic [cpvp_pkg::DIST_W-1:0]         rem_q;
	logic [cpvp_pkg::DIST_W-1:0]         dvs_q;
	logic                                neg_q;
	logic [cpvp_pkg::SPD_W-1:0]          spd_mag;
	logic [cpvp_pkg::DIST_W:0]           trial;
	logic [cpvp_pkg::DIST_W:0]           trial_sub;
	logic                                ge;

	assign spd_mag   = spd[cpvp_pkg::SPD_W-1] ? cpvp_pkg::SPD_W'(-spd) : spd;
	assign trial     = {rem_q, dq_q[cpvp_pkg::RATIO_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {spd_mag, 16'd0};
			rem_q <= '0;
			dvs_q <= err;
			neg_q <= spd[cpvp_pkg::SPD_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[cpvp_pkg::DIST_W-1:0] : trial[cpvp_pkg::DIST_W-1:0];
			dq_q  <= {dq_q[cpvp_pkg::RATIO_W-2:0], ge};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.ratio = neg_q ? -dq_q : dq_q;

endmodule

@@ src/cascaded_position_velocity_pid.sv @@
// Top level: cascaded position/velocity controller with incremental PID on one shared multiplier.
// Depends on cpvp_pkg and cpvp_div.
//
//  channel | dir | handshake               | payload
//  s_axis  | in  | s_axis_tvalid/tready    | tdata: pos_error, speed; tuser: action
//  m_axis  | out | m_axis_tvalid/tready    | tdata: throttle, brake, arrived
//  cfg     | in  | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// A normal tick runs DES, ERR, MULP, MULI, MULD, ADDD, ACC, PED, RES, FIN; DES, MULP, MULI,
// MULD and PED use the shared 33x33 multiplier. A new plan with positive error first waits in
// DIV for the bit-serial divider. A tick after the target was reached goes straight to FIN.
// Reset clears all loop state and loads register defaults. A full output register stalls
// the last step; input is taken only when idle.
module cascaded_position_velocity_pid #(
	parameter int GAIN_TABLE_ENTRIES = 64,
	parameter int ACCUM_WIDTH        = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [23:0] pos_error, [39:24] speed
	input  logic        s_axis_tuser,   // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [15:0] throttle, [31:16] brake, [32] arrived
	input  logic                                  cfg_we,
	input  logic [cpvp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cpvp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int IDX_W   = $clog2(GAIN_TABLE_ENTRIES);
	localparam int MAG_W   = ((ACCUM_WIDTH > 32) ? ACCUM_WIDTH : 32) + 1;
	localparam int DELTA_W = 42;
	localparam int SUM_W   = ((ACCUM_WIDTH > DELTA_W) ? ACCUM_WIDTH : DELTA_W) + 2;
	localparam logic signed [SUM_W-1:0] ACC_MAX =
		SUM_W'((64'sd1 <<< (ACCUM_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
	localparam logic [7:0] BAND_TOP = 8'(GAIN_TABLE_ENTRIES - 1);
	localparam logic signed [40:0] E_MAX = 41'sd8388607;
	localparam logic signed [40:0] E_MIN = -41'sd8388608;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_DES  = 4'd2;
	localparam logic [3:0] S_ERR  = 4'd3;
	localparam logic [3:0] S_MULP = 4'd4;
	localparam logic [3:0] S_MULI = 4'd5;
	localparam logic [3:0] S_MULD = 4'd6;
	localparam logic [3:0] S_ADDD = 4'd7;
	localparam logic [3:0] S_ACC  = 4'd8;
	localparam logic [3:0] S_PED  = 4'd9;
	localparam logic [3:0] S_RES  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0] state_q;

	logic [cpvp_pkg::GAIN_W-1:0] ki_q, kd_q, thr_ratio_q, brk_ratio_q, stop_lvl_q;
	logic [cpvp_pkg::DIST_W-1:0] arr_dist_q;

	logic                                 reached_q;
	logic signed [cpvp_pkg::RATIO_W-1:0]  ratio_q;
	logic signed [ACCUM_WIDTH-1:0]        acc_q;
	logic signed [cpvp_pkg::ERR_W-1:0]    e1_q, e2_q;

	logic signed [cpvp_pkg::ERR_W-1:0]    err_q;
	logic signed [cpvp_pkg::SPD_W-1:0]    spd_q;
	logic                                 plan_q;
	logic signed [cpvp_pkg::ERR_W-1:0]    e_q;
	logic [31:0]                          kp_q;
	logic signed [65:0]                   prod_q;
	logic signed [SUM_W-1:0]              sum_q;
	logic [15:0]                          res_thr_q, res_brk_q;
	logic                                 res_arr_q;
	logic                                 m_tvalid_q;
	logic [39:0]                          out_data_q;

	logic                                 in_fire;
	logic                                 in_action;
	logic signed [cpvp_pkg::ERR_W-1:0]    in_err;
	logic signed [cpvp_pkg::SPD_W-1:0]    in_spd;
	logic                                 in_err_pos;
	logic                                 div_start;
	cpvp_pkg::div_rsp_t                   div_rsp;
	logic                                 out_free;

	logic [31:0]                          gain_rom [GAIN_TABLE_ENTRIES];
	logic [7:0]                           spd_band;
	logic [IDX_W-1:0]                     kp_idx;

	logic signed [39:0]                   desired;
	logic signed [40:0]                   des_diff;
	logic signed [cpvp_pkg::ERR_W-1:0]    e_sat;
	logic signed [24:0]                   e_d1;
	logic signed [25:0]                   e_d2;
	logic signed [49:0]                   sh16;
	logic signed [57:0]                   sh8;
	logic signed [32:0]                   mul_a, mul_b;
	logic signed [65:0]                   mul_p;
	logic signed [MAG_W-1:0]              acc_ext;
	logic [MAG_W-1:0]                     acc_mag;
	logic                                 acc_pos;
	logic                                 acc_hi;
	logic [cpvp_pkg::GAIN_W-1:0]          ped_ratio;
	logic [15:0]                          ped_val;
	logic                                 arrive;

	generate
		for (genvar gi = 0; gi < GAIN_TABLE_ENTRIES; gi++) begin : g_rom
			localparam logic [31:0] GV = cpvp_pkg::gain_entry(gi);
			assign gain_rom[gi] = GV;
		end
	endgenerate

	assign in_action  = s_axis_tuser;
	assign in_err     = s_axis_tdata[23:0];
	assign in_spd     = s_axis_tdata[39:24];
	assign in_err_pos = !in_err[cpvp_pkg::ERR_W-1] && (|in_err[cpvp_pkg::ERR_W-2:0]);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign div_start  = in_fire && in_action && in_err_pos;
	assign out_free   = !m_tvalid_q || m_axis_tready;

	cpvp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.spd    (in_spd),
		.err    (in_err[cpvp_pkg::DIST_W-1:0]),
		.rsp    (div_rsp)
	);

	assign spd_band = spd_q[14:7];
	assign kp_idx   = spd_q[cpvp_pkg::SPD_W-1] ? '0 :
		(spd_band > BAND_TOP) ? IDX_W'(GAIN_TABLE_ENTRIES - 1) : IDX_W'(spd_band);

	assign desired  = prod_q[55:16];
	assign des_diff = 41'(desired) - 41'(spd_q);
	assign e_sat    = (des_diff > E_MAX) ? cpvp_pkg::ERR_W'(E_MAX) :
		(des_diff < E_MIN) ? cpvp_pkg::ERR_W'(E_MIN) : des_diff[cpvp_pkg::ERR_W-1:0];

	assign e_d1 = 25'(e_q) - 25'(e1_q);
	assign e_d2 = 26'(e_q) - 26'(e1_q) - 26'(e1_q) + 26'(e2_q);
	assign sh16 = prod_q[65:16];
	assign sh8  = prod_q[65:8];

	assign acc_pos   = !acc_q[ACCUM_WIDTH-1];
	assign acc_ext   = MAG_W'(acc_q);
	assign acc_mag   = acc_pos ? acc_ext : MAG_W'(-acc_ext);
	assign acc_hi    = |acc_mag[MAG_W-1:32];
	assign ped_ratio = acc_pos ? thr_ratio_q : brk_ratio_q;
	assign ped_val   = ((acc_hi && ped_ratio != '0) || (|prod_q[47:32])) ?
		16'hFFFF : prod_q[31:16];
	assign arrive    = (spd_q < cpvp_pkg::SLOW_SPEED) ||
		(err_q < $signed({1'b0, arr_dist_q}));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DES: begin
				mul_a = 33'(err_q);
				mul_b = 33'(ratio_q);
			end
			S_MULP: begin
				mul_a = {1'b0, kp_q};
				mul_b = 33'(e_d1);
			end
			S_MULI: begin
				mul_a = {17'd0, ki_q};
				mul_b = 33'(e_q);
			end
			S_MULD: begin
				mul_a = {17'd0, kd_q};
				mul_b = 33'(e_d2);
			end
			S_PED: begin
				mul_a = {17'd0, ped_ratio};
				mul_b = {1'b0, acc_mag[31:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 66'(mul_a) * 66'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ki_q        <= '0;
			kd_q        <= '0;
			thr_ratio_q <= 16'd256;
			brk_ratio_q <= 16'd256;
			arr_dist_q  <= 23'd26;
			stop_lvl_q  <= 16'd3000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpvp_pkg::CFG_INTEGRAL_GAIN:    ki_q        <= cfg_wdata[15:0];
				cpvp_pkg::CFG_DERIVATIVE_GAIN:  kd_q        <= cfg_wdata[15:0];
				cpvp_pkg::CFG_THROTTLE_RATIO:   thr_ratio_q <= cfg_wdata[15:0];
				cpvp_pkg::CFG_BRAKE_RATIO:      brk_ratio_q <= cfg_wdata[15:0];
				cpvp_pkg::CFG_ARRIVE_DISTANCE:  arr_dist_q  <= cfg_wdata;
				cpvp_pkg::CFG_STOP_BRAKE_LEVEL: stop_lvl_q  <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			reached_q  <= 1'b0;
			ratio_q    <= '0;
			acc_q      <= '0;
			e1_q       <= '0;
			e2_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_axis_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_action) begin
							reached_q <= 1'b0;
							if (in_err_pos) begin
								state_q <= S_DIV;
							end else begin
								ratio_q <= '0;
								state_q <= S_DES;
							end
						end else if (reached_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DES;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						ratio_q <= div_rsp.ratio;
						state_q <= S_DES;
					end
				end
				S_DES:  state_q <= S_ERR;
				S_ERR:  state_q <= S_MULP;
				S_MULP: state_q <= S_MULI;
				S_MULI: state_q <= S_MULD;
				S_MULD: state_q <= S_ADDD;
				S_ADDD: state_q <= S_ACC;
				S_ACC: begin
					if (!plan_q)
						acc_q <= (sum_q > ACC_MAX) ? ACCUM_WIDTH'(ACC_MAX) :
							(sum_q < ACC_MIN) ? ACCUM_WIDTH'(ACC_MIN) : ACCUM_WIDTH'(sum_q);
					e2_q    <= e1_q;
					e1_q    <= e_q;
					state_q <= S_PED;
				end
				S_PED: state_q <= S_RES;
				S_RES: begin
					if (arrive)
						reached_q <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q     <= in_err;
			spd_q     <= in_spd;
			plan_q    <= in_action;
			res_thr_q <= '0;
			res_brk_q <= stop_lvl_q;
			res_arr_q <= 1'b1;
		end
		unique case (state_q)
			S_DES, S_MULP, S_PED: prod_q <= mul_p;
			S_ERR: begin
				e_q   <= e_sat;
				kp_q  <= gain_rom[kp_idx];
				sum_q <= SUM_W'(acc_q);
			end
			S_MULI: begin
				sum_q  <= sum_q + SUM_W'(sh16);
				prod_q <= mul_p;
			end
			S_MULD: begin
				sum_q  <= sum_q + SUM_W'(sh8);
				prod_q <= mul_p;
			end
			S_ADDD: sum_q <= sum_q + SUM_W'(sh8);
			S_RES: begin
				if (arrive) begin
					res_thr_q <= '0;
					res_brk_q <= stop_lvl_q;
					res_arr_q <= 1'b1;
				end else begin
					res_thr_q <= acc_pos ? ped_val : 16'd0;
					res_brk_q <= acc_pos ? 16'd0 : ped_val;
					res_arr_q <= 1'b0;
				end
			end
			S_FIN: begin
				if (out_free)
					out_data_q <= {7'd0, res_arr_q, res_brk_q, res_thr_q};
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = out_data_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide step");

	a_arrived_no_throttle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[32]) |-> m_axis_tdata[15:0] == 16'd0)
		else $error("throttle applied on an arrived word");

	a_reached_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(reached_q && !(in_fire && in_action)) |=> reached_q)
		else $error("reached latch dropped without a new plan");

	a_idle_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !div_rsp.done) |=> state_q == S_DIV)
		else $error("left the divide step before the quotient was ready");

endmodule
